// ===== hw/rtl/srr_pkg.sv =====
`timescale 1ns / 1ps
// srr_pkg: window and sequence constants, beat types of the
// selective repeat receiver. no dependencies.
package srr_pkg;

  localparam int WINDOW       = 4;
  localparam int SEQ_SPACE    = 8;
  localparam int PAYLOAD_BITS = 64;

  localparam int SEQ_W   = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1;
  localparam int WIN_IW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DIST_W  = 8;
  localparam int PREV_LO = (SEQ_SPACE > WINDOW) ? SEQ_SPACE - WINDOW : 0;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  typedef struct packed {
    logic        checksum_ok;
    logic [2:0]  seq_num;
    logic [63:0] payload;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  out_seq;
    logic [63:0] out_payload;
    logic        last;
  } out_beat_t;

endpackage

// ===== hw/rtl/selective_repeat_receiver_unit.sv =====
`timescale 1ns / 1ps
// Selective repeat ARQ receiver: reorder buffer and in-order release.
// depends on srr_pkg.
//
// A packet beat is taken while the sequencer sits at its fetch step. A good
// packet inside the receive window is buffered once; the packet at the window
// base releases every consecutive buffered payload in order, then an
// acknowledgement carrying the packet's own number closes the sequence with
// last set. Packets in the previous window are only acknowledged; corrupt or
// out-of-range packets produce nothing. A dropped packet passes the fetch and
// classify steps; a packet that is only acknowledged adds the head check and
// the acknowledgement. A packet at the window base passes fetch, classify,
// head check, one release step per payload plus the step that finds the run
// ended, and the acknowledgement. The microcode program steps one control
// word per cycle while the output does not hold it. One result register
// sits on the output, so the next packet is accepted while the final
// acknowledgement waits to be taken.
module selective_repeat_receiver_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  srr_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output srr_pkg::out_beat_t out_beat_o
);

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LATCH,
    OP_STORE,
    OP_RELEASE,
    OP_ACK
  } op_e;

  typedef enum logic [2:0] {
    C_IN_BEAT,
    C_DROP,
    C_NOT_HEAD,
    C_SLOT0,
    C_ALWAYS
  } cond_e;

  typedef logic [2:0] step_t;

  typedef struct packed {
    op_e   op;
    logic  uses_out;
    cond_e cond;
    step_t taken;
    step_t fall;
  } cw_t;

  localparam step_t S_FETCH    = 3'd0;
  localparam step_t S_CLASSIFY = 3'd1;
  localparam step_t S_HEAD     = 3'd2;
  localparam step_t S_RELEASE  = 3'd3;
  localparam step_t S_ACK      = 3'd4;

  function automatic cw_t rom(input step_t a);
    cw_t w;
    unique case (a)
      S_FETCH:    w = '{OP_LATCH,   1'b0, C_IN_BEAT,  S_CLASSIFY, S_FETCH};
      S_CLASSIFY: w = '{OP_STORE,   1'b0, C_DROP,     S_FETCH,    S_HEAD};
      S_HEAD:     w = '{OP_NOP,     1'b0, C_NOT_HEAD, S_ACK,      S_RELEASE};
      S_RELEASE:  w = '{OP_RELEASE, 1'b1, C_SLOT0,    S_RELEASE,  S_ACK};
      S_ACK:      w = '{OP_ACK,     1'b1, C_ALWAYS,   S_FETCH,    S_FETCH};
      default:    w = '{OP_NOP,     1'b0, C_ALWAYS,   S_FETCH,    S_FETCH};
    endcase
    return w;
  endfunction

  step_t                          step_q, step_d;
  srr_pkg::in_beat_t              pkt_q;
  logic [srr_pkg::SEQ_W-1:0]      base_q, base_d;
  logic [srr_pkg::WINDOW-1:0]     valid_q, valid_d;
  logic [srr_pkg::PAYLOAD_BITS-1:0] slot_q [srr_pkg::WINDOW];
  logic                           out_valid_q, out_valid_d;
  srr_pkg::out_beat_t             out_q, out_d;

  cw_t                            cw;
  logic                           out_free, hold, cond_hit, in_take;
  logic [srr_pkg::DIST_W-1:0]     dist_raw, win_ofs;
  logic                           seq_ok, in_win, drop, do_store, do_shift;
  logic [srr_pkg::WIN_IW-1:0]     wr_idx;

  assign cw       = rom(step_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign hold     = cw.uses_out && !out_free;
  assign in_take  = (cw.op == OP_LATCH) && in_valid_i;

  assign in_stall_o  = (cw.op != OP_LATCH);
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // window distance of the held packet
  always_comb begin
    dist_raw = srr_pkg::DIST_W'(pkt_q.seq_num) + srr_pkg::DIST_W'(srr_pkg::SEQ_SPACE)
             - srr_pkg::DIST_W'(base_q);
    win_ofs = (dist_raw >= srr_pkg::DIST_W'(srr_pkg::SEQ_SPACE)) ?
              dist_raw - srr_pkg::DIST_W'(srr_pkg::SEQ_SPACE) : dist_raw;
    seq_ok = srr_pkg::DIST_W'(pkt_q.seq_num) < srr_pkg::DIST_W'(srr_pkg::SEQ_SPACE);
    in_win = pkt_q.checksum_ok && seq_ok && (win_ofs < srr_pkg::DIST_W'(srr_pkg::WINDOW));
    drop   = !pkt_q.checksum_ok || !seq_ok ||
             (!in_win && (win_ofs < srr_pkg::DIST_W'(srr_pkg::PREV_LO)));
    wr_idx = win_ofs[srr_pkg::WIN_IW-1:0];
  end

  always_comb begin
    unique case (cw.cond)
      C_IN_BEAT:  cond_hit = in_valid_i;
      C_DROP:     cond_hit = drop;
      C_NOT_HEAD: cond_hit = (win_ofs != '0);
      C_SLOT0:    cond_hit = valid_q[0];
      C_ALWAYS:   cond_hit = 1'b1;
      default:    cond_hit = 1'b1;
    endcase
  end

  assign do_store = (cw.op == OP_STORE) && in_win && !valid_q[wr_idx];
  assign do_shift = (cw.op == OP_RELEASE) && !hold && valid_q[0];

  always_comb begin
    step_d      = hold ? step_q : (cond_hit ? cw.taken : cw.fall);
    base_d      = base_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (do_store) begin
      valid_d[wr_idx] = 1'b1;
    end
    if (do_shift) begin
      valid_d = valid_q >> 1;
      base_d  = (base_q == srr_pkg::SEQ_W'(srr_pkg::SEQ_SPACE - 1)) ? '0 :
                base_q + srr_pkg::SEQ_W'(1);
      out_valid_d     = 1'b1;
      out_d.kind      = srr_pkg::KIND_DELIVER;
      out_d.out_seq   = 3'(base_q);
      out_d.out_payload = 64'(slot_q[0]);
      out_d.last      = 1'b0;
    end
    if ((cw.op == OP_ACK) && !hold) begin
      out_valid_d     = 1'b1;
      out_d.kind      = srr_pkg::KIND_ACK;
      out_d.out_seq   = pkt_q.seq_num;
      out_d.out_payload = '0;
      out_d.last      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_FETCH;
      base_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      base_q      <= base_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload datapath, no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_take) begin
      pkt_q <= in_beat_i;
    end
    if (do_store) begin
      slot_q[wr_idx] <= pkt_q.payload[srr_pkg::PAYLOAD_BITS-1:0];
    end
    if (do_shift) begin
      for (int k = 0; k < srr_pkg::WINDOW - 1; k++) begin
        slot_q[k] <= slot_q[k+1];
      end
    end
  end

endmodule

// ===== tb/srr_checker.sv =====
`timescale 1ns / 1ps
// srr_checker: mirrors the receive window of the selective repeat receiver,
// predicts the delivery and ack beats of each packet and compares them in
// order as they leave the block. depends on srr_pkg.
module srr_checker
  import srr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_beat_t  in_beat_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_beat_t out_beat_i,
  output int        errors_o,
  output int        pending_o,
  output int        delivered_o,
  output int        acked_o
);

  localparam int REPORT_MAX = 10;

  logic [SEQ_W-1:0]        base_q;
  logic [WINDOW-1:0]       held_q;
  logic [PAYLOAD_BITS-1:0] held_word_q [WINDOW];
  out_beat_t               due_results [$];

  task automatic queue_result(input logic kind, input logic [SEQ_W-1:0] seq,
                              input logic [63:0] word, input logic last);
    out_beat_t r;
    r.kind        = kind;
    r.out_seq     = seq;
    r.out_payload = word;
    r.last        = last;
    due_results.push_back(r);
  endtask

  task automatic absorb_packet(input in_beat_t pkt);
    int ofs;
    if (!pkt.checksum_ok || int'(pkt.seq_num) >= SEQ_SPACE) return;
    ofs = (int'(pkt.seq_num) + SEQ_SPACE - int'(base_q)) % SEQ_SPACE;
    if (ofs < WINDOW) begin
      if (!held_q[ofs]) begin
        held_q[ofs]      = 1'b1;
        held_word_q[ofs] = pkt.payload[PAYLOAD_BITS-1:0];
      end
      if (ofs == 0) begin
        // release the run of buffered payloads starting at the base
        while (held_q[0]) begin
          queue_result(KIND_DELIVER, base_q, 64'(held_word_q[0]), 1'b0);
          for (int k = 0; k < WINDOW - 1; k++) begin
            held_word_q[k] = held_word_q[k+1];
          end
          held_q = held_q >> 1;
          base_q = SEQ_W'((int'(base_q) + 1) % SEQ_SPACE);
        end
      end
    end else if (ofs < SEQ_SPACE - WINDOW) begin
      return;
    end
    queue_result(KIND_ACK, pkt.seq_num, '0, 1'b1);
  endtask

  task automatic check_result(input out_beat_t got);
    out_beat_t want;
    if (got.kind == KIND_DELIVER) delivered_o++;
    else acked_o++;
    if (due_results.size() == 0) begin
      errors_o++;
      if (errors_o <= REPORT_MAX) begin
        $display("unexpected beat: kind %0d seq %0d payload %h last %0d",
                 got.kind, got.out_seq, got.out_payload, got.last);
      end
      return;
    end
    want = due_results.pop_front();
    if (got.kind !== want.kind || got.out_seq !== want.out_seq ||
        got.out_payload !== want.out_payload || got.last !== want.last) begin
      errors_o++;
      if (errors_o <= REPORT_MAX) begin
        $display("mismatch: want kind %0d seq %0d payload %h last %0d",
                 want.kind, want.out_seq, want.out_payload, want.last);
        $display("           got kind %0d seq %0d payload %h last %0d",
                 got.kind, got.out_seq, got.out_payload, got.last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      = '0;
      held_q      = '0;
      due_results.delete();
      errors_o    = 0;
      delivered_o = 0;
      acked_o     = 0;
    end else begin
      // outputs first: a beat leaving now cannot stem from a packet taken now
      if (out_valid_i && !out_stall_i) check_result(out_beat_i);
      if (in_valid_i && !in_stall_i) absorb_packet(in_beat_i);
    end
    pending_o = due_results.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: stimulus and verdict for selective_repeat_receiver_unit; packet beats
// in shuffled windows with noise, random output stalls and one long hold-off.
// depends on srr_pkg, selective_repeat_receiver_unit and srr_checker.
module tb;
  import srr_pkg::*;

  localparam int GOOD_ITEMS   = 425;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_CYCLES  = 400;
  localparam int CALM_LO      = 260;
  localparam int CALM_HI      = 340;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 300000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_beat;

  int errors;
  int pending;
  int delivered;
  int acked;
  int good_sent;
  int bad_sent;
  int cycles;
  logic [SEQ_W-1:0] tx_base;
  logic held_off;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  selective_repeat_receiver_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  srr_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_beat_i  (out_beat),
    .errors_o    (errors),
    .pending_o   (pending),
    .delivered_o (delivered),
    .acked_o     (acked)
  );

  function automatic logic calm_stretch();
    return good_sent >= CALM_LO && good_sent < CALM_HI;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 15))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      default: begin
        return {$urandom(), $urandom()};
      end
    endcase
  endfunction

  function automatic logic [SEQ_W-1:0] seq_at(input logic [SEQ_W-1:0] b, input int off);
    return SEQ_W'((int'(b) + off + 2 * SEQ_SPACE) % SEQ_SPACE);
  endfunction

  task automatic send_packet(input logic ok, input logic [SEQ_W-1:0] seq,
                             input logic [63:0] word);
    while (!calm_stretch() && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_beat.checksum_ok <= ok;
    in_beat.seq_num     <= seq;
    in_beat.payload     <= word;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
    if (ok) good_sent++;
    else bad_sent++;
  endtask

  // receiver side: random stalls, one long hold-off to back the block up
  initial begin
    out_stall = 1'b0;
    held_off  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held_off && good_sent >= HOLD_AT) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= !calm_stretch() && $urandom_range(0, 99) < 14;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int span;
    int pick;
    int tmp;
    int roll;
    int order [$];
    in_valid  = 1'b0;
    in_beat   = '0;
    good_sent = 0;
    bad_sent  = 0;
    rst_n     = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // corrupt base packet is dropped, then in-order packets with extreme payloads
    send_packet(1'b0, 3'd0, '1);
    send_packet(1'b1, 3'd0, '0);
    send_packet(1'b1, 3'd1, '1);
    // out of order, duplicate keeps the first payload, base releases four
    send_packet(1'b1, 3'd3, 64'h0123_4567_89ab_cdef);
    send_packet(1'b1, 3'd5, 64'h8000_0000_0000_0001);
    send_packet(1'b1, 3'd4, 64'hffff_0000_ffff_0000);
    send_packet(1'b1, 3'd4, 64'h5555_5555_5555_5555);
    send_packet(1'b1, 3'd2, 64'haaaa_aaaa_aaaa_aaaa);
    // previous window, ack only
    send_packet(1'b1, 3'd3, rand_word());
    send_packet(1'b1, 3'd2, rand_word());
    // corrupt packet inside the window is not buffered
    send_packet(1'b0, 3'd7, rand_word());
    // release across the sequence wrap
    send_packet(1'b1, 3'd7, rand_word());
    send_packet(1'b1, 3'd0, rand_word());
    send_packet(1'b1, 3'd1, rand_word());
    send_packet(1'b1, 3'd6, rand_word());
    send_packet(1'b0, 3'd2, '1);
    tx_base = 3'd2;

    // whole windows in shuffled order, with corrupt beats and retransmits
    while (good_sent < GOOD_ITEMS) begin
      span = $urandom_range(1, WINDOW);
      order.delete();
      for (int j = 0; j < span; j++) order.push_back(j);
      for (int j = span - 1; j > 0; j--) begin
        pick        = $urandom_range(0, j);
        tmp         = order[j];
        order[j]    = order[pick];
        order[pick] = tmp;
      end
      for (int j = 0; j < span; j++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          send_packet(1'b0, SEQ_W'($urandom_range(0, SEQ_SPACE - 1)), rand_word());
        end else if (roll < 16 && j > 0) begin
          send_packet(1'b1, seq_at(tx_base, order[$urandom_range(0, j - 1)]), rand_word());
        end else if (roll < 22 && j == 0) begin
          send_packet(1'b1, seq_at(tx_base, -int'($urandom_range(1, WINDOW))), rand_word());
        end
        send_packet(1'b1, seq_at(tx_base, order[j]), rand_word());
      end
      tx_base = seq_at(tx_base, span);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("run covered %0d good and %0d corrupt packets: %0d deliveries, %0d acks",
             good_sent, bad_sent, delivered, acked);
    $display("output held off for %0d cycles once, random stalls on both sides",
             HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/srr_pkg.sv
hw/rtl/selective_repeat_receiver_unit.sv
tb/srr_checker.sv
tb/tb.sv
